// File: src/pmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pmt_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 56;

  localparam logic [2:0] ACT_FIND      = 3'd0;
  localparam logic [2:0] ACT_FIND_PORT = 3'd1;
  localparam logic [2:0] ACT_ADD       = 3'd2;
  localparam logic [2:0] ACT_REMOVE    = 3'd3;
  localparam logic [2:0] ACT_SEEN      = 3'd4;

  localparam logic [1:0] CODE_MATCH = 2'd0;
  localparam logic [1:0] CODE_NEW   = 2'd1;
  localparam logic [1:0] CODE_MISS  = 2'd2;
  localparam logic [1:0] CODE_FULL  = 2'd3;

  localparam logic [1:0] STATUS_ALIVE = 2'd0;

  typedef struct packed {
    logic        used;
    logic [31:0] address;
    logic [15:0] port;
    logic [1:0]  status;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] address;
    logic [15:0] port;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [5:0]  slot;
    logic [1:0]  status;
    logic [31:0] stamp;
    logic [6:0]  count;
  } res_t;

endpackage

`default_nettype wire

// File: src/pmt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/pmt_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module pmt_engine #(
  parameter int TABLE_SLOTS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire pmt_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output pmt_pkg::res_t      res
);

  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int NW = $clog2(TABLE_SLOTS + 1);
  localparam int EW = $bits(pmt_pkg::entry_t);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t          state_r;
  pmt_pkg::req_t   req_r;
  logic [NW-1:0]   iss_r;
  logic            pend_r;
  logic [AW-1:0]   chk_r;
  logic            hit_r;
  logic [AW-1:0]   hit_slot_r;
  pmt_pkg::entry_t hit_entry_r;
  logic            free_r;
  logic [AW-1:0]   free_slot_r;
  logic [NW-1:0]   cnt_r;
  logic [NW-1:0]   cnt_nxt;
  logic [AW-1:0]   clr_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  pmt_pkg::entry_t ram_wdata;
  logic [AW-1:0]   ram_raddr;
  pmt_pkg::entry_t ram_rdata;

  logic            is_match;
  logic            issue;
  logic            is_ins;
  logic            fire;
  pmt_pkg::entry_t new_entry;
  pmt_pkg::entry_t wr_entry;
  logic [AW-1:0]   wr_slot;
  logic            do_wr;
  logic [1:0]      res_code;
  logic [AW-1:0]   res_slot;
  logic [1:0]      res_status;
  logic [31:0]     res_stamp;
  logic [31:0]     slot_w;
  logic [31:0]     cnt_w;

  pmt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign fire      = res_valid && res_ready;
  assign ram_raddr = iss_r[AW-1:0];
  assign issue     = (state_r == ST_SCAN) && (iss_r < NW'(TABLE_SLOTS));
  assign is_ins    = (req_r.action == pmt_pkg::ACT_ADD) || (req_r.action == pmt_pkg::ACT_SEEN);

  assign is_match = ram_rdata.used && (ram_rdata.port == req_r.port) &&
                    ((req_r.action == pmt_pkg::ACT_FIND_PORT) ||
                     (ram_rdata.address == req_r.address));

  always_comb begin
    new_entry.used    = 1'b1;
    new_entry.address = req_r.address;
    new_entry.port    = req_r.port;
    new_entry.status  = pmt_pkg::STATUS_ALIVE;
    new_entry.stamp   = req_r.now;
  end

  // result and write-back decision from the finished walk
  always_comb begin
    res_code   = pmt_pkg::CODE_MISS;
    res_slot   = '0;
    res_status = '0;
    res_stamp  = '0;
    wr_entry   = new_entry;
    wr_slot    = hit_slot_r;
    do_wr      = 1'b0;
    cnt_nxt    = cnt_r;
    if (hit_r) begin
      res_code   = pmt_pkg::CODE_MATCH;
      res_slot   = hit_slot_r;
      res_status = hit_entry_r.status;
      res_stamp  = hit_entry_r.stamp;
      if (req_r.action == pmt_pkg::ACT_SEEN) begin
        do_wr      = 1'b1;
        res_status = pmt_pkg::STATUS_ALIVE;
        res_stamp  = req_r.now;
      end else if (req_r.action == pmt_pkg::ACT_REMOVE) begin
        do_wr         = 1'b1;
        wr_entry      = hit_entry_r;
        wr_entry.used = 1'b0;
        cnt_nxt       = cnt_r - NW'(1);
      end
    end else if (is_ins && free_r) begin
      res_code   = pmt_pkg::CODE_NEW;
      res_slot   = free_slot_r;
      res_status = pmt_pkg::STATUS_ALIVE;
      res_stamp  = req_r.now;
      wr_slot    = free_slot_r;
      do_wr      = 1'b1;
      cnt_nxt    = cnt_r + NW'(1);
    end else if (is_ins) begin
      res_code = pmt_pkg::CODE_FULL;
    end
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = fire && do_wr;
      ram_waddr = wr_slot;
      ram_wdata = wr_entry;
    end
  end

  assign slot_w     = 32'(res_slot);
  assign cnt_w      = 32'(cnt_nxt);
  assign res.code   = res_code;
  assign res.slot   = slot_w[5:0];
  assign res.status = res_status;
  assign res.stamp  = res_stamp;
  assign res.count  = cnt_w[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      iss_r   <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(TABLE_SLOTS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            req_r  <= req;
            iss_r  <= '0;
            pend_r <= 1'b0;
            hit_r  <= 1'b0;
            free_r <= 1'b0;
            unique case (req.action) inside
              pmt_pkg::ACT_FIND, pmt_pkg::ACT_FIND_PORT, pmt_pkg::ACT_ADD,
              pmt_pkg::ACT_REMOVE, pmt_pkg::ACT_SEEN: state_r <= ST_SCAN;
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          pend_r <= issue;
          chk_r  <= iss_r[AW-1:0];
          if (issue) begin
            iss_r <= iss_r + NW'(1);
          end
          if (pend_r) begin
            if (is_match) begin
              hit_r       <= 1'b1;
              hit_slot_r  <= chk_r;
              hit_entry_r <= ram_rdata;
              state_r     <= ST_DONE;
            end else begin
              if (!ram_rdata.used && !free_r) begin
                free_r      <= 1'b1;
                free_slot_r <= chk_r;
              end
              if (chk_r == AW'(TABLE_SLOTS - 1)) begin
                state_r <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            cnt_r   <= cnt_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(TABLE_SLOTS))
    else $error("used count beyond table size");

  a_write_when: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR) || fire)
    else $error("table write outside clear or result handoff");

  a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_code == pmt_pkg::CODE_NEW) |=> cnt_r == $past(cnt_r) + NW'(1))
    else $error("insert did not bump used count");

  a_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && hit_r) |-> hit_entry_r.used)
    else $error("hit on an unused slot");

endmodule

`default_nettype wire

// File: src/peer_membership_table_unit.sv
// Peer membership table. After reset the table memory is cleared one slot per cycle,
// all TABLE_SLOTS slots, before the first request is taken. Each request walks the table
// from slot 0 upward, one slot read per cycle from the single table memory, stopping at
// the first matching used slot; an insert, a seen refresh or a remove then writes its
// entry back when the result is handed on. Requests are handled one at a time. Requests
// with an unknown action skip the walk and answer as not found. A result register sits on
// the output, so the next request can enter while the previous result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module peer_membership_table_unit #(
  parameter int TABLE_SLOTS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // action[2:0], peer_address[34:3], peer_port[50:35], now_seconds[82:51]
  input  wire logic [pmt_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // result_code[1:0], slot_index[7:2], entry_status[9:8], entry_last_seen[41:10],
  // used_count[48:42]
  output logic      [pmt_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  pmt_pkg::req_t req;
  pmt_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;
  logic          out_tvalid_r;
  logic [pmt_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  assign req.action  = in_tdata[2:0];
  assign req.address = in_tdata[34:3];
  assign req.port    = in_tdata[50:35];
  assign req.now     = in_tdata[82:51];

  pmt_engine #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= {7'd0, res.count, res.stamp, res.status, res.slot, res.code};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// File: tb/pmt_checker.sv
`timescale 1ns / 1ps

module pmt_checker #(
  parameter int SLOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pmt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pmt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output int                              full_answers,
  output int                              hit_answers
);

  logic          used_q   [SLOTS];
  logic [31:0]   addr_q   [SLOTS];
  logic [15:0]   port_q   [SLOTS];
  logic [1:0]    status_q [SLOTS];
  logic [31:0]   stamp_q  [SLOTS];
  int unsigned   live_total;
  pmt_pkg::res_t answers_due[$];

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      used_q[i]   = 1'b0;
      addr_q[i]   = '0;
      port_q[i]   = '0;
      status_q[i] = '0;
      stamp_q[i]  = '0;
    end
    live_total   = 0;
    fail_count   = 0;
    pending      = 0;
    checked      = 0;
    full_answers = 0;
    hit_answers  = 0;
  end

  function automatic int find_slot(logic [31:0] a, logic [15:0] p, bit port_only);
    for (int i = 0; i < SLOTS; i++) begin
      if (used_q[i] && port_q[i] == p && (port_only || addr_q[i] == a)) return i;
    end
    return SLOTS;
  endfunction

  function automatic int claim_entry(input logic [31:0] a, input logic [15:0] p,
                                     input logic [31:0] t, output logic [1:0] code);
    int hit;
    hit = find_slot(a, p, 1'b0);
    if (hit != SLOTS) begin
      code = pmt_pkg::CODE_MATCH;
      return hit;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!used_q[i]) begin
        used_q[i]   = 1'b1;
        addr_q[i]   = a;
        port_q[i]   = p;
        status_q[i] = pmt_pkg::STATUS_ALIVE;
        stamp_q[i]  = t;
        live_total++;
        code = pmt_pkg::CODE_NEW;
        return i;
      end
    end
    code = pmt_pkg::CODE_FULL;
    return SLOTS;
  endfunction

  function automatic pmt_pkg::res_t predict_answer(pmt_pkg::req_t r);
    pmt_pkg::res_t res;
    int            slot;
    logic [1:0]    code;
    slot = SLOTS;
    code = pmt_pkg::CODE_MISS;
    case (r.action)
      pmt_pkg::ACT_FIND, pmt_pkg::ACT_FIND_PORT: begin
        slot = find_slot(r.address, r.port, r.action == pmt_pkg::ACT_FIND_PORT);
        if (slot != SLOTS) code = pmt_pkg::CODE_MATCH;
      end
      pmt_pkg::ACT_ADD: begin
        slot = claim_entry(r.address, r.port, r.now, code);
      end
      pmt_pkg::ACT_REMOVE: begin
        slot = find_slot(r.address, r.port, 1'b0);
        if (slot != SLOTS) begin
          used_q[slot] = 1'b0;
          live_total--;
          code = pmt_pkg::CODE_MATCH;
        end
      end
      pmt_pkg::ACT_SEEN: begin
        slot = claim_entry(r.address, r.port, r.now, code);
        if (slot != SLOTS) begin
          stamp_q[slot]  = r.now;
          status_q[slot] = pmt_pkg::STATUS_ALIVE;
        end
      end
      default: begin
      end
    endcase
    res = '0;
    res.code = code;
    if (slot != SLOTS) begin
      res.slot   = 6'(slot);
      res.status = status_q[slot];
      res.stamp  = stamp_q[slot];
    end
    res.count = 7'(live_total);
    return res;
  endfunction

  always @(posedge clk) begin
    pmt_pkg::req_t req;
    pmt_pkg::res_t want;
    pmt_pkg::res_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        req.action  = in_tdata[2:0];
        req.address = in_tdata[34:3];
        req.port    = in_tdata[50:35];
        req.now     = in_tdata[82:51];
        answers_due.push_back(predict_answer(req));
      end
      if (out_tvalid && out_tready) begin
        got.code   = out_tdata[1:0];
        got.slot   = out_tdata[7:2];
        got.status = out_tdata[9:8];
        got.stamp  = out_tdata[41:10];
        got.count  = out_tdata[48:42];
        if (answers_due.size() == 0) begin
          $error("result with no request waiting: %h", out_tdata);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          checked++;
          if (want.code == pmt_pkg::CODE_FULL) full_answers++;
          if (want.code == pmt_pkg::CODE_MATCH) hit_answers++;
          if (got.code !== want.code) begin
            $error("result_code: expected %0d, got %0d", want.code, got.code);
            fail_count++;
          end
          if (got.slot !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("entry_status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.stamp !== want.stamp) begin
            $error("entry_last_seen: expected %h, got %h", want.stamp, got.stamp);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("used_count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
        end
      end
    end
    pending <= answers_due.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS        = 64;
  localparam int RANDOM_ITEMS = 1130;
  localparam int STALL_LIMIT  = 4000;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic [pmt_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pmt_pkg::OUT_TDATA_W-1:0] out_tdata;

  int fail_count, pending, checked, full_answers, hit_answers;
  int sent;
  int burst_left;
  int idle_cycles;

  logic [31:0] addr_pool[16];
  logic [15:0] port_pool[8];

  peer_membership_table_unit #(.TABLE_SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  pmt_checker #(.SLOTS(SLOTS)) table_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .full_answers(full_answers),
    .hit_answers (hit_answers)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random stall pattern, picked anew for each block of random length
  initial begin
    int mode;
    int phase;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        phase++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= ($urandom_range(0, 5) == 0);
          default: out_tready <= (phase % 4 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL peer_membership_table_unit");
        $finish;
      end
    end
  end

  task automatic send_request(logic [2:0] act, logic [31:0] a, logic [15:0] p,
                              logic [31:0] t);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tdata  <= {{(pmt_pkg::IN_TDATA_W - 83){1'b0}}, t, p, a, act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic random_request(int mode);
    int          r;
    int          c0, c1, c2, c3, c4;
    logic [2:0]  act;
    logic [31:0] a;
    logic [15:0] p;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        c0 = 10; c1 = 17; c2 = 57; c3 = 62; c4 = 97;
      end
      MODE_SHRINK: begin
        c0 = 15; c1 = 25; c2 = 35; c3 = 80; c4 = 90;
      end
      default: begin
        c0 = 20; c1 = 35; c2 = 55; c3 = 75; c4 = 95;
      end
    endcase
    if (r < c0) act = pmt_pkg::ACT_FIND;
    else if (r < c1) act = pmt_pkg::ACT_FIND_PORT;
    else if (r < c2) act = pmt_pkg::ACT_ADD;
    else if (r < c3) act = pmt_pkg::ACT_REMOVE;
    else if (r < c4) act = pmt_pkg::ACT_SEEN;
    else act = pmt_pkg::ACT_SEEN + 3'($urandom_range(1, 3));
    a = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 15)];
    p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 7)];
    case ($urandom_range(0, 19))
      0: t = '0;
      1: t = '1;
      default: t = $urandom;
    endcase
    send_request(act, a, p, t);
  endtask

  initial begin
    int mode;
    int block_left;
    sent       = 0;
    burst_left = 0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 16; i++) addr_pool[i] = $urandom;
    port_pool[0] = '0;
    port_pool[1] = '1;
    for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty table misses
    send_request(pmt_pkg::ACT_FIND, 32'h0, 16'h0, 32'h0);
    send_request(pmt_pkg::ACT_FIND_PORT, 32'h0, 16'h0, 32'h0);
    send_request(pmt_pkg::ACT_REMOVE, 32'h0, 16'h0, 32'h0);
    // inserts, repeat add keeps stamp, seen restamps
    send_request(pmt_pkg::ACT_ADD, 32'h0, 16'h0, 32'h0);
    send_request(pmt_pkg::ACT_ADD, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    send_request(pmt_pkg::ACT_ADD, 32'h0, 16'h0, 32'h5);
    send_request(pmt_pkg::ACT_SEEN, 32'h0, 16'h0, 32'h7b);
    send_request(pmt_pkg::ACT_SEEN, 32'h1234_5678, 16'hffff, 32'h8000_0000);
    send_request(pmt_pkg::ACT_FIND, 32'hffff_ffff, 16'hffff, 32'h0);
    send_request(pmt_pkg::ACT_FIND_PORT, 32'h0, 16'hffff, 32'h0);
    send_request(pmt_pkg::ACT_FIND, 32'h0, 16'hffff, 32'h0);
    // remove frees the lowest slot, add reuses it
    send_request(pmt_pkg::ACT_REMOVE, 32'h0, 16'h0, 32'h0);
    send_request(pmt_pkg::ACT_FIND, 32'h0, 16'h0, 32'h0);
    send_request(pmt_pkg::ACT_ADD, 32'haaaa_aaaa, 16'h5555, 32'h5555_5555);
    send_request(pmt_pkg::ACT_REMOVE, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    send_request(pmt_pkg::ACT_SEEN, 32'h0, 16'h0, 32'hffff_ffff);
    // unused action codes
    for (int k = 1; k <= 3; k++) begin
      send_request(pmt_pkg::ACT_SEEN + 3'(k), 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    end
    send_request(pmt_pkg::ACT_FIND_PORT, 32'h5555_5555, 16'h5555, 32'h0);
    send_request(pmt_pkg::ACT_REMOVE, 32'h1234_5678, 16'hffff, 32'h0);
    send_request(pmt_pkg::ACT_SEEN, 32'h0, 16'h0, 32'h1);

    // first block fills the table far enough to hit full
    mode = MODE_GROW;
    block_left = 220;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (block_left == 0) begin
        mode = $urandom_range(MODE_GROW, MODE_MIXED);
        block_left = $urandom_range(80, 200);
      end
      block_left--;
      random_request(mode);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SLOTS + 16) @(posedge clk);

    $display("sent %0d requests over all actions and unused codes, table filled and drained",
             sent);
    $display("compared %0d results: %0d hits, %0d table-full answers",
             checked, hit_answers, full_answers);
    if (fail_count == 0) begin
      $display("PASS peer_membership_table_unit");
    end else begin
      $display("FAIL peer_membership_table_unit");
    end
    $finish;
  end

endmodule
